// ===== src/swlh_pkg.sv =====
// Shared types and constants for the stopwatch with lap hold.
// Used by the channel interfaces and by the core; depends on nothing else.
`default_nettype none

package swlh_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned TENS_W   = 3;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Operation codes of an input transaction
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // Ladder reading when no button is pressed
    localparam logic [SAMPLE_W-1:0] NO_BUTTON = 8'd255;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAP_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAP_HIGH   = 2'd3;

    // Window bounds after reset (exclusive)
    localparam logic [SAMPLE_W-1:0] START_LOW_RST  = 8'd45;
    localparam logic [SAMPLE_W-1:0] START_HIGH_RST = 8'd60;
    localparam logic [SAMPLE_W-1:0] LAP_LOW_RST    = 8'd95;
    localparam logic [SAMPLE_W-1:0] LAP_HIGH_RST   = 8'd110;

    // Mode codes as seen on the result channel
    localparam logic [MODE_W-1:0] MODE_CODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_RUNNING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_LAP     = 2'd2;

    // Last value of each digit before it wraps
    localparam logic [TENS_W-1:0]  TENS_MAX  = 3'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef enum logic [2:0] {
        ST_STOPPED = 3'b001,
        ST_RUNNING = 3'b010,
        ST_LAP     = 3'b100
    } mode_state_t;

    typedef struct packed {
        logic [TENS_W-1:0]  tens;
        logic [DIGIT_W-1:0] ones;
        logic [DIGIT_W-1:0] tenths;
    } bcd_time_t;

    localparam bcd_time_t TIME_ZERO = '{tens: '0, ones: '0, tenths: '0};

endpackage

`default_nettype wire

// ===== src/swlh_if.sv =====
// Valid/ready channel interfaces of the stopwatch: input items, results
// and configuration writes. Depends on swlh_pkg.
`default_nettype none

interface swlh_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [swlh_pkg::SAMPLE_W-1:0] button_sample;

    modport source (output valid, output operation, output button_sample, input ready);
    modport sink   (input valid, input operation, input button_sample, output ready);
endinterface

interface swlh_out_if;
    logic                         valid;
    logic                         ready;
    logic [swlh_pkg::MODE_W-1:0]  mode;
    logic [swlh_pkg::TENS_W-1:0]  shown_tens;
    logic [swlh_pkg::DIGIT_W-1:0] shown_ones;
    logic [swlh_pkg::DIGIT_W-1:0] shown_tenths;
    logic                         display_written;

    modport source (output valid, output mode, output shown_tens, output shown_ones,
                    output shown_tenths, output display_written, input ready);
    modport sink   (input valid, input mode, input shown_tens, input shown_ones,
                    input shown_tenths, input display_written, output ready);
endinterface

interface swlh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swlh_pkg::CFG_IDX_W-1:0]  index;
    logic [swlh_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/stopwatch_with_lap_hold_core.sv =====
// Stopwatch core with lap hold: input register, one update pass, result.
// Depends on swlh_pkg and the channel interfaces in swlh_if.sv.
`default_nettype none

// Stopwatch with lap hold. Each input transaction is either a tenth-second
// tick or a button ladder sample, and each one yields exactly one result
// transaction carrying the mode after the item, the displayed time and a
// flag telling whether this item rewrote the display. A transaction is
// first held in an input register, then a single pass of short logic
// updates the mode, the BCD count (00.0 to 59.9, wrapping) and the display,
// and loads the result. The result fields are the state registers themselves
// plus a registered written flag, so a new item can be taken every cycle
// while results drain: one item per clock sustained. The result is loaded
// and offered once the result slot is free. The input
// register is refilled while a result waits, and only blocks when both it
// and the result are full and the result is not being taken. Configuration
// writes are always accepted and take effect on the next edge; write the
// window bounds only while no item is in flight. A sample of 255 never
// matches a window, and the start/stop window wins where both windows match.
module stopwatch_with_lap_hold_core (
    input  wire           clk,
    input  wire           rst_n,
    swlh_in_if.sink       in_ch,
    swlh_out_if.source    out_ch,
    swlh_cfg_if.sink      cfg
);

    // Configuration registers
    logic [swlh_pkg::SAMPLE_W-1:0] start_low_reg;
    logic [swlh_pkg::SAMPLE_W-1:0] start_high_reg;
    logic [swlh_pkg::SAMPLE_W-1:0] lap_low_reg;
    logic [swlh_pkg::SAMPLE_W-1:0] lap_high_reg;

    // Input register
    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [swlh_pkg::SAMPLE_W-1:0] in_sample_reg;

    // Stopwatch state, also the visible part of the result
    swlh_pkg::mode_state_t mode_reg;
    swlh_pkg::mode_state_t mode_next;
    swlh_pkg::bcd_time_t   count_reg;
    swlh_pkg::bcd_time_t   count_next;
    swlh_pkg::bcd_time_t   disp_reg;
    swlh_pkg::bcd_time_t   disp_next;

    // Result register
    logic out_valid_reg;
    logic written_reg;
    logic written_next;

    logic                in_accept;
    logic                advance;
    logic                hit_start;
    logic                hit_lap;
    swlh_pkg::bcd_time_t count_inc;

    // Move an item into the result when the result slot is free or drains now
    assign advance   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_accept = in_ch.valid && in_ch.ready;

    assign cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg  <= swlh_pkg::START_LOW_RST;
            start_high_reg <= swlh_pkg::START_HIGH_RST;
            lap_low_reg    <= swlh_pkg::LAP_LOW_RST;
            lap_high_reg   <= swlh_pkg::LAP_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                swlh_pkg::REG_START_LOW:  start_low_reg  <= cfg.data;
                swlh_pkg::REG_START_HIGH: start_high_reg <= cfg.data;
                swlh_pkg::REG_LAP_LOW:    lap_low_reg    <= cfg.data;
                swlh_pkg::REG_LAP_HIGH:   lap_high_reg   <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // Input register: control under reset, payload captured on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg     <= in_ch.operation;
            in_sample_reg <= in_ch.button_sample;
        end
    end

    // Window match; an idle ladder never counts as a press
    assign hit_start = (in_sample_reg != swlh_pkg::NO_BUTTON)
                    && (in_sample_reg > start_low_reg)
                    && (in_sample_reg < start_high_reg);
    assign hit_lap   = (in_sample_reg != swlh_pkg::NO_BUTTON)
                    && (in_sample_reg > lap_low_reg)
                    && (in_sample_reg < lap_high_reg);

    // Advance the BCD count by one tenth, wrap 59.9 to 00.0
    always_comb
    begin
        count_inc = count_reg;
        if (count_reg.tenths == swlh_pkg::DIGIT_MAX)
        begin
            count_inc.tenths = '0;
            if (count_reg.ones == swlh_pkg::DIGIT_MAX)
            begin
                count_inc.ones = '0;
                if (count_reg.tens == swlh_pkg::TENS_MAX)
                begin
                    count_inc.tens = '0;
                end
                else
                begin
                    count_inc.tens = count_reg.tens + 1'b1;
                end
            end
            else
            begin
                count_inc.ones = count_reg.ones + 1'b1;
            end
        end
        else
        begin
            count_inc.tenths = count_reg.tenths + 1'b1;
        end
    end

    // One update pass for the item in the input register
    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        disp_next    = disp_reg;
        written_next = 1'b0;
        priority if (in_op_reg == swlh_pkg::OP_TICK)
        begin
            // Count while running or in lap; only running refreshes the display
            if (mode_reg != swlh_pkg::ST_STOPPED)
            begin
                count_next = count_inc;
            end
            if (mode_reg == swlh_pkg::ST_RUNNING)
            begin
                disp_next    = count_inc;
                written_next = 1'b1;
            end
        end
        else if (hit_start)
        begin
            mode_next = (mode_reg == swlh_pkg::ST_RUNNING) ? swlh_pkg::ST_STOPPED
                                                           : swlh_pkg::ST_RUNNING;
        end
        else if (hit_lap)
        begin
            unique case (mode_reg)
                swlh_pkg::ST_STOPPED:
                begin
                    // Clear time and display
                    count_next   = swlh_pkg::TIME_ZERO;
                    disp_next    = swlh_pkg::TIME_ZERO;
                    written_next = 1'b1;
                end
                swlh_pkg::ST_RUNNING: mode_next = swlh_pkg::ST_LAP;
                swlh_pkg::ST_LAP:     mode_next = swlh_pkg::ST_RUNNING;
                default:              mode_next = mode_reg;
            endcase
        end
        else
        begin
            // No button or no window hit: hold everything
        end
    end

    // State and result update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= swlh_pkg::ST_STOPPED;
            count_reg     <= swlh_pkg::TIME_ZERO;
            disp_reg      <= swlh_pkg::TIME_ZERO;
            out_valid_reg <= 1'b0;
            written_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg      <= mode_next;
                count_reg     <= count_next;
                disp_reg      <= disp_next;
                written_reg   <= written_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields straight from the state; state moves only with the result
    always_comb
    begin
        unique case (mode_reg)
            swlh_pkg::ST_STOPPED: out_ch.mode = swlh_pkg::MODE_CODE_STOPPED;
            swlh_pkg::ST_RUNNING: out_ch.mode = swlh_pkg::MODE_CODE_RUNNING;
            swlh_pkg::ST_LAP:     out_ch.mode = swlh_pkg::MODE_CODE_LAP;
            default:              out_ch.mode = swlh_pkg::MODE_CODE_STOPPED;
        endcase
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.shown_tens      = disp_reg.tens;
    assign out_ch.shown_ones      = disp_reg.ones;
    assign out_ch.shown_tenths    = disp_reg.tenths;
    assign out_ch.display_written = written_reg;

`ifndef ASSERT_OFF
    // The count never leaves 00.0 .. 59.9
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg.tens <= swlh_pkg::TENS_MAX) && (count_reg.ones <= swlh_pkg::DIGIT_MAX)
        && (count_reg.tenths <= swlh_pkg::DIGIT_MAX))
        else $error("count out of BCD range");

    // A rewritten display shows the current count
    a_written_shows_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && written_reg |-> disp_reg == count_reg)
        else $error("written display differs from count");

    // Lap hold never reports a display write
    a_lap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (mode_reg == swlh_pkg::ST_LAP) |-> !written_reg)
        else $error("display written in lap hold");

    // A tick while stopped leaves the count alone
    a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == swlh_pkg::OP_TICK) && (mode_reg == swlh_pkg::ST_STOPPED)
        |=> $stable(count_reg) && $stable(disp_reg))
        else $error("stopped tick changed time");

    // State moves only when a result is loaded
    a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg) && $stable(mode_reg) && $stable(disp_reg))
        else $error("state changed without a result");
`endif

endmodule

`default_nettype wire
